/* rtl/dcsc_pkg.sv */
// Shared types and constants of the day cycle sky color engine.
// Holds the command struct, code enums and palette tables used by the
// controller and the datapath. Depends on nothing.
package dcsc_pkg;

   // Working width of the remainder register; holds clock plus largest advance step.
   localparam int SUM_W      = 30;
   // Counter width for reduction and division steps.
   localparam int CNT_W      = 5;
   // Quotient bits of the blend position.
   localparam int FRAC_W     = 16;
   localparam int DIV_LAST   = FRAC_W - 1;
   // Compare width for tick thresholds.
   localparam int CMP_W      = 18;
   localparam int CHAN_W     = 3;
   localparam int NUM_CHAN   = 6;
   localparam int CSR_IDX_W  = 1;
   localparam int PROD_W     = 27;

   localparam logic [CHAN_W-1:0] LAST_CHAN = CHAN_W'(NUM_CHAN - 1);

   typedef enum logic [1:0] {
      REQ_ADVANCE = 2'd0,
      REQ_SET     = 2'd1,
      REQ_FLASH   = 2'd2,
      REQ_NONE    = 2'd3
   } req_code_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DAY_SPEED  = 1'b0,
      CSR_RAIN_LEVEL = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      MIX_PHASE = 2'd0,
      MIX_RAIN  = 2'd1,
      MIX_FLASH = 2'd2
   } mix_stage_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_MUL,
      S_LOAD,
      S_REDUCE,
      S_COMMIT,
      S_PHASE,
      S_DIV,
      S_MIX,
      S_LAST,
      S_DONE
   } ctrl_state_type;

   typedef struct packed {
      logic                capture;
      logic                mult;
      logic                load;
      logic                reduce;
      logic                commit;
      logic                div;
      logic                mix;
      logic                store;
      logic                out_load;
      logic [CNT_W-1:0]    k;
      logic [CHAN_W-1:0]   chan;
      mix_stage_type       stage;
      logic [CHAN_W-1:0]   store_chan;
   } dp_cmd_type;

   // Palette keys: dawn, day, dusk, night; zenith rgb then horizon rgb.
   localparam logic [7:0] SKY_KEYS [4][NUM_CHAN] = '{
      '{8'd128, 8'd102, 8'd153, 8'd255, 8'd153, 8'd77},
      '{8'd128, 8'd179, 8'd255, 8'd204, 8'd230, 8'd255},
      '{8'd102, 8'd77,  8'd128, 8'd255, 8'd128, 8'd51},
      '{8'd0,   8'd0,   8'd26,  8'd26,  8'd26,  8'd51}
   };

   localparam logic [7:0] RAIN_KEYS [NUM_CHAN] = '{
      8'd102, 8'd102, 8'd115, 8'd128, 8'd128, 8'd140
   };

endpackage

/* rtl/dcsc_datapath.sv */
// Datapath of the sky color engine: clock and flash state, config registers,
// shared compare-subtract unit, shared blend multiplier and result registers.
// Depends on dcsc_pkg; driven by dcsc_ctrl through dp_cmd_type.
module dcsc_datapath #(
   parameter int DAY_LENGTH = 24000
) (
   input  logic                              clock,
   input  logic                              reset,
   input  dcsc_pkg::dp_cmd_type              cmd,
   input  logic [1:0]                        req_type,
   input  logic [15:0]                       req_delta_time,
   input  logic [15:0]                       req_set_ticks,
   input  logic                              csr_write,
   input  logic [dcsc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [15:0]                       csr_data,
   output logic [7:0]                        rsp_zenith_red,
   output logic [7:0]                        rsp_zenith_green,
   output logic [7:0]                        rsp_zenith_blue,
   output logic [7:0]                        rsp_horizon_red,
   output logic [7:0]                        rsp_horizon_green,
   output logic [7:0]                        rsp_horizon_blue,
   output logic [1:0]                        rsp_day_phase,
   output logic                              rsp_sun_visible,
   output logic                              rsp_moon_visible,
   output logic                              rsp_stars_visible,
   output logic [14:0]                       rsp_clock_ticks
);
   import dcsc_pkg::*;

   localparam int SPAN     = DAY_LENGTH * 256;
   localparam int CLK_W    = $clog2(SPAN);
   localparam int OFF      = (DAY_LENGTH * 769 + 12000) / 24000;
   localparam int HALF     = DAY_LENGTH / 2;
   localparam int STAR_LIM = (DAY_LENGTH * 13 * 256) / 24;

   localparam logic [SUM_W-1:0] SPAN_V     = SUM_W'(SPAN);
   localparam logic [SUM_W-1:0] STAR_V     = SUM_W'(STAR_LIM);
   localparam logic [CMP_W-1:0] OFF_V      = CMP_W'(OFF);
   localparam logic [CMP_W-1:0] SUN_LO_V   = CMP_W'(HALF + OFF);
   localparam logic [CMP_W-1:0] DAY_V      = CMP_W'(DAY_LENGTH);
   localparam logic [CMP_W-1:0] HALF_V     = CMP_W'(HALF);
   localparam logic [16:0]      FLASH_FULL = 17'd65536;

   // state and config
   logic [CLK_W-1:0]   clock_ff, clock_in;
   logic [16:0]        flash_ff, flash_in;
   logic [15:0]        speed_ff, speed_in;
   logic [8:0]         rain_ff, rain_in;

   // captured request
   req_code_type       type_ff, type_in;
   logic [15:0]        delta_ff, delta_in;
   logic [15:0]        set_ff, set_in;

   // arithmetic
   logic [31:0]        mul_ff, mul_in;
   logic [SUM_W-1:0]   r_ff, r_in;
   logic [1:0]         phase_ff, phase_in;
   logic [FRAC_W-1:0]  t_ff, t_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic [7:0]         acc_ff, acc_in;
   logic [7:0]         col_ff [NUM_CHAN];

   // output registers
   logic [7:0]         out_col_ff [NUM_CHAN];
   logic [1:0]         out_phase_ff;
   logic               out_sun_ff, out_moon_ff, out_stars_ff;
   logic [14:0]        out_ticks_ff;

   // compare-subtract unit
   logic [SUM_W-1:0]   cand, subv;
   logic [SUM_W:0]     diff_w;
   logic               take;
   logic [SUM_W-1:0]   r_step;

   logic [36:0]        inc_full;
   logic [SUM_W-1:0]   inc_v;
   logic [26:0]        dec_v;

   // blend
   logic signed [PROD_W:0] rnd_sum;
   logic signed [11:0]     mix_res;
   logic [7:0]             mix_a, mix_b;
   logic [16:0]            mix_w;
   logic signed [8:0]      mix_d;
   logic [1:0]             phase_nxt;
   logic [16:0]            rain_w;

   // tick flags
   logic [CMP_W-1:0]   ticks;
   logic               sun_off, moon_off;

   always_comb begin
      cand   = cmd.div ? {r_ff[SUM_W-2:0], 1'b0} : r_ff;
      subv   = cmd.div ? SPAN_V : (SPAN_V << cmd.k);
      diff_w = {1'b0, cand} - {1'b0, subv};
      take   = !diff_w[SUM_W];
      r_step = take ? diff_w[SUM_W-1:0] : cand;
   end

   assign inc_full = {1'b0, mul_ff, 4'b0} + {3'b0, mul_ff, 2'b0};
   assign inc_v    = SUM_W'(inc_full[36:8]);
   assign dec_v    = {1'b0, delta_ff, 10'b0} + {3'b0, delta_ff, 8'b0};

   always_comb begin
      type_in  = type_ff;
      delta_in = delta_ff;
      set_in   = set_ff;
      if (cmd.capture) begin
         type_in  = req_code_type'(req_type);
         delta_in = req_delta_time;
         set_in   = req_set_ticks;
      end
   end

   always_comb begin
      speed_in = speed_ff;
      rain_in  = rain_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_DAY_SPEED:  speed_in = csr_data;
            CSR_RAIN_LEVEL: rain_in  = csr_data[8:0];
            default:        speed_in = speed_ff;
         endcase
      end
   end

   always_comb begin
      mul_in   = cmd.mult ? (delta_ff * speed_ff) : mul_ff;
      flash_in = flash_ff;
      if (cmd.mult) begin
         unique case (type_ff)
            REQ_ADVANCE: flash_in = ({10'b0, flash_ff} > dec_v)
                                    ? 17'(({10'b0, flash_ff} - dec_v)) : 17'd0;
            REQ_FLASH:   flash_in = FLASH_FULL;
            default:     flash_in = flash_ff;
         endcase
      end
   end

   always_comb begin
      r_in     = r_ff;
      clock_in = clock_ff;
      phase_in = phase_ff;
      t_in     = t_ff;
      priority if (cmd.load) begin
         unique case (type_ff)
            REQ_ADVANCE: r_in = SUM_W'(clock_ff) + inc_v;
            REQ_SET:     r_in = SUM_W'({set_ff, 8'b0});
            default:     r_in = SUM_W'(clock_ff);
         endcase
      end else if (cmd.commit) begin
         clock_in = r_ff[CLK_W-1:0];
         r_in     = {r_ff[SUM_W-3:0], 2'b00};
      end else if (cmd.reduce) begin
         r_in     = r_step;
         phase_in = {phase_ff[0], take};
      end else if (cmd.div) begin
         r_in = r_step;
         t_in = {t_ff[FRAC_W-2:0], take};
      end
   end

   // blend: a + round((b - a) * w / 65536)
   assign rnd_sum   = {prod_ff[PROD_W-1], prod_ff} + (PROD_W+1)'(32768);
   assign mix_res   = {4'b0, acc_ff} + rnd_sum[PROD_W:PROD_W-11];
   assign phase_nxt = phase_ff + 2'd1;
   assign rain_w    = (rain_ff > 9'd256) ? 17'd65536 : {rain_ff, 8'b0};

   always_comb begin
      unique case (cmd.stage)
         MIX_PHASE: begin
            mix_a = SKY_KEYS[phase_ff][cmd.chan];
            mix_b = SKY_KEYS[phase_nxt][cmd.chan];
            mix_w = {1'b0, t_ff};
         end
         MIX_RAIN: begin
            mix_a = mix_res[7:0];
            mix_b = RAIN_KEYS[cmd.chan];
            mix_w = rain_w;
         end
         MIX_FLASH: begin
            mix_a = mix_res[7:0];
            mix_b = 8'd255;
            mix_w = {1'b0, flash_ff[16:1]};
         end
         default: begin
            mix_a = mix_res[7:0];
            mix_b = mix_res[7:0];
            mix_w = 17'd0;
         end
      endcase
      mix_d   = $signed({1'b0, mix_b}) - $signed({1'b0, mix_a});
      prod_in = cmd.mix ? (PROD_W'(mix_d) * PROD_W'($signed({1'b0, mix_w}))) : prod_ff;
      acc_in  = cmd.mix ? mix_a : acc_ff;
   end

   assign ticks    = CMP_W'(clock_ff[CLK_W-1:8]);
   assign sun_off  = (ticks >= SUN_LO_V) && ((ticks + OFF_V) < DAY_V);
   assign moon_off = (ticks >= OFF_V) && ((ticks + OFF_V) < HALF_V);

   always_ff @(posedge clock) begin
      if (reset) begin
         clock_ff <= '0;
         flash_ff <= '0;
         speed_ff <= 16'd256;
         rain_ff  <= '0;
      end else begin
         clock_ff <= clock_in;
         flash_ff <= flash_in;
         speed_ff <= speed_in;
         rain_ff  <= rain_in;
      end
   end

   always_ff @(posedge clock) begin
      type_ff  <= type_in;
      delta_ff <= delta_in;
      set_ff   <= set_in;
      mul_ff   <= mul_in;
      r_ff     <= r_in;
      phase_ff <= phase_in;
      t_ff     <= t_in;
      prod_ff  <= prod_in;
      acc_ff   <= acc_in;
      if (cmd.store) begin
         col_ff[cmd.store_chan] <= mix_res[7:0];
      end
      if (cmd.out_load) begin
         out_col_ff   <= col_ff;
         out_phase_ff <= phase_ff;
         out_sun_ff   <= !sun_off;
         out_moon_ff  <= !moon_off;
         out_stars_ff <= (SUM_W'(clock_ff) <= STAR_V);
         out_ticks_ff <= ticks[14:0];
      end
   end

   assign rsp_zenith_red    = out_col_ff[0];
   assign rsp_zenith_green  = out_col_ff[1];
   assign rsp_zenith_blue   = out_col_ff[2];
   assign rsp_horizon_red   = out_col_ff[3];
   assign rsp_horizon_green = out_col_ff[4];
   assign rsp_horizon_blue  = out_col_ff[5];
   assign rsp_day_phase     = out_phase_ff;
   assign rsp_sun_visible   = out_sun_ff;
   assign rsp_moon_visible  = out_moon_ff;
   assign rsp_stars_visible = out_stars_ff;
   assign rsp_clock_ticks   = out_ticks_ff;

   a_clock_in_day: assert property (@(posedge clock) disable iff (reset)
      SUM_W'(clock_ff) < SPAN_V)
      else $error("day clock left its range");

   a_flash_bound: assert property (@(posedge clock) disable iff (reset)
      flash_ff <= FLASH_FULL)
      else $error("flash level above full");

   a_mix_range: assert property (@(posedge clock) disable iff (reset)
      cmd.store |-> (mix_res[11:8] == 4'd0))
      else $error("blend result out of 8-bit range");

endmodule

/* rtl/dcsc_ctrl.sv */
// Controller of the sky color engine: sequences one transaction through
// multiply, reduction, phase split, division and blend steps.
// Depends on dcsc_pkg; drives dcsc_datapath through dp_cmd_type.
module dcsc_ctrl #(
   parameter int REDUCE_LAST = 7
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output dcsc_pkg::dp_cmd_type  cmd
);
   import dcsc_pkg::*;

   ctrl_state_type      state_ff, state_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [CHAN_W-1:0]   chan_ff, chan_in;
   mix_stage_type       stage_ff, stage_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:   if (req_valid) state_in = S_MUL;
         S_MUL:    state_in = S_LOAD;
         S_LOAD:   state_in = S_REDUCE;
         S_REDUCE: if (cnt_ff == '0) state_in = S_COMMIT;
         S_COMMIT: state_in = S_PHASE;
         S_PHASE:  if (cnt_ff == '0) state_in = S_DIV;
         S_DIV:    if (cnt_ff == '0) state_in = S_MIX;
         S_MIX:    if (chan_ff == LAST_CHAN && stage_ff == MIX_FLASH) state_in = S_LAST;
         S_LAST:   state_in = S_DONE;
         S_DONE:   if (out_free) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   // commands and counters
   always_comb begin
      cmd          = '0;
      cmd.k        = cnt_ff;
      cmd.chan     = chan_ff;
      cmd.stage    = stage_ff;
      cmd.store_chan = chan_ff - CHAN_W'(1);
      cnt_in       = cnt_ff;
      chan_in      = chan_ff;
      stage_in     = stage_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         S_IDLE: begin
            cmd.capture = req_valid;
         end
         S_MUL: begin
            cmd.mult = 1'b1;
         end
         S_LOAD: begin
            cmd.load = 1'b1;
            cnt_in   = CNT_W'(REDUCE_LAST);
         end
         S_REDUCE: begin
            cmd.reduce = 1'b1;
            cnt_in     = cnt_ff - CNT_W'(1);
         end
         S_COMMIT: begin
            cmd.commit = 1'b1;
            cnt_in     = CNT_W'(1);
         end
         S_PHASE: begin
            cmd.reduce = 1'b1;
            cnt_in     = (cnt_ff == '0) ? CNT_W'(DIV_LAST) : cnt_ff - CNT_W'(1);
         end
         S_DIV: begin
            cmd.div  = 1'b1;
            cnt_in   = cnt_ff - CNT_W'(1);
            chan_in  = '0;
            stage_in = MIX_PHASE;
         end
         S_MIX: begin
            cmd.mix   = 1'b1;
            cmd.store = (stage_ff == MIX_PHASE) && (chan_ff != '0);
            unique case (stage_ff)
               MIX_PHASE: stage_in = MIX_RAIN;
               MIX_RAIN:  stage_in = MIX_FLASH;
               MIX_FLASH: begin
                  stage_in = MIX_PHASE;
                  chan_in  = chan_ff + CHAN_W'(1);
               end
               default:   stage_in = MIX_PHASE;
            endcase
         end
         S_LAST: begin
            cmd.store      = 1'b1;
            cmd.store_chan = LAST_CHAN;
         end
         S_DONE: begin
            cmd.out_load = out_free;
            if (out_free) rsp_valid_in = 1'b1;
         end
         default: begin
            cmd.capture = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
         chan_ff      <= '0;
         stage_ff     <= MIX_PHASE;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
         chan_ff      <= chan_in;
         stage_ff     <= stage_in;
      end
   end

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_DONE))
      else $error("result raised outside the done state");

   a_done_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && rsp_valid_ff && rsp_stall) |=> (state_ff == S_DONE))
      else $error("finished result overwrote a pending one");

   a_chan_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MIX) |-> (chan_ff <= LAST_CHAN))
      else $error("blend channel counter out of range");

endmodule

/* rtl/day_cycle_sky_color_engine.sv */
// Steps: multiply, load, reduction, commit, phase split, division, blend, last
// store, done. The shared compare-subtract unit does R+1 reduction, 2 phase
// and 16 division steps and the shared blend multiplier does 18 steps. R is
// 30 - bits(DAY_LENGTH*256), R = 7 at DAY_LENGTH 24000. req_stall holds new
// requests until the controller is idle again. Reset: synchronous, active high;
// clock and flash clear, day_speed returns to 256 and rain_level to 0.
module day_cycle_sky_color_engine #(
   parameter int DAY_LENGTH = 24000
) (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [1:0]                        req_type,
   input  logic [15:0]                       req_delta_time,
   input  logic [15:0]                       req_set_ticks,
   // result channel
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [7:0]                        rsp_zenith_red,
   output logic [7:0]                        rsp_zenith_green,
   output logic [7:0]                        rsp_zenith_blue,
   output logic [7:0]                        rsp_horizon_red,
   output logic [7:0]                        rsp_horizon_green,
   output logic [7:0]                        rsp_horizon_blue,
   output logic [1:0]                        rsp_day_phase,
   output logic                              rsp_sun_visible,
   output logic                              rsp_moon_visible,
   output logic                              rsp_stars_visible,
   output logic [14:0]                       rsp_clock_ticks,
   // configuration write channel
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [dcsc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [15:0]                       csr_data
);
   import dcsc_pkg::*;

   // Largest shift of the shifted-span subtract steps that reduce any clock plus
   // advance step below one day; the steps run from this shift down to zero.
   localparam int REDUCE_LAST = SUM_W - $clog2(DAY_LENGTH * 256 + 1);

   dp_cmd_type cmd;

   // Config writes are taken at any time; software writes only while idle.
   assign csr_ready = 1'b1;

   // Controller: accepts one transaction, walks the sequence, then holds the
   // result in the output register until the consumer takes it. A new
   // transaction may be accepted while that result still waits.
   dcsc_ctrl #(
      .REDUCE_LAST (REDUCE_LAST)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   // Datapath: day clock in Q.8 ticks, flash level in Q1.16, config
   // registers, the reduce/divide unit and the blend multiplier.
   dcsc_datapath #(
      .DAY_LENGTH (DAY_LENGTH)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .req_type          (req_type),
      .req_delta_time    (req_delta_time),
      .req_set_ticks     (req_set_ticks),
      .csr_write         (csr_valid && csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .rsp_zenith_red    (rsp_zenith_red),
      .rsp_zenith_green  (rsp_zenith_green),
      .rsp_zenith_blue   (rsp_zenith_blue),
      .rsp_horizon_red   (rsp_horizon_red),
      .rsp_horizon_green (rsp_horizon_green),
      .rsp_horizon_blue  (rsp_horizon_blue),
      .rsp_day_phase     (rsp_day_phase),
      .rsp_sun_visible   (rsp_sun_visible),
      .rsp_moon_visible  (rsp_moon_visible),
      .rsp_stars_visible (rsp_stars_visible),
      .rsp_clock_ticks   (rsp_clock_ticks)
   );

endmodule
